### design/edf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_pkg: shared types for the edf ready queue
// item layouts, entry layout, status codes and key helpers
// ----------------------------------------------------------------------------
package edf_pkg;

  localparam int unsigned IdW   = 8;
  localparam int unsigned SecW  = 32;
  localparam int unsigned UsecW = 20;
  localparam int unsigned OccW  = 5;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } edf_op_e;

  typedef enum logic [1:0] {
    ST_PUSHED     = 2'd0,
    ST_POPPED     = 2'd1,
    ST_POP_EMPTY  = 2'd2,
    ST_PUSH_FULL  = 2'd3
  } edf_status_e;

  typedef struct packed {
    edf_op_e           op;
    logic [IdW-1:0]    task_id;
    logic [SecW-1:0]   remaining_sec;
    logic [UsecW-1:0]  remaining_usec;
    logic [SecW-1:0]   period_sec;
    logic [UsecW-1:0]  period_usec;
  } edf_in_t;

  typedef struct packed {
    edf_status_e       status;
    logic [IdW-1:0]    out_task_id;
    logic [SecW-1:0]   out_key_sec;
    logic [UsecW-1:0]  out_key_usec;
    logic [OccW-1:0]   occupancy;
  } edf_out_t;

  // one stored task, both time values kept
  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [SecW-1:0]   rem_sec;
    logic [UsecW-1:0]  rem_usec;
    logic [SecW-1:0]   per_sec;
    logic [UsecW-1:0]  per_usec;
  } edf_entry_t;

  typedef struct packed {
    logic [SecW-1:0]   sec;
    logic [UsecW-1:0]  usec;
  } edf_key_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
    logic by_period;
  } edf_ctrl_t;

  function automatic edf_key_t key_of(input edf_entry_t e, input logic by_period);
    edf_key_t k;
    if (by_period) begin
      k.sec  = e.per_sec;
      k.usec = e.per_usec;
    end else begin
      k.sec  = e.rem_sec;
      k.usec = e.rem_usec;
    end
    return k;
  endfunction

  // seconds first, then microseconds, as one unsigned compare
  function automatic logic key_less(input edf_key_t a, input edf_key_t b);
    return {a.sec, a.usec} < {b.sec, b.usec};
  endfunction

endpackage

### design/edf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_cell: one slot of the sorted queue
// holds one task, compares against the new task, shifts with its neighbors
// ----------------------------------------------------------------------------
module edf_cell (
  input  logic                clk_i,
  input  edf_pkg::edf_ctrl_t  ctrl_i,
  input  logic                occupied_i,
  input  edf_pkg::edf_entry_t new_i,
  input  edf_pkg::edf_entry_t left_i,
  input  edf_pkg::edf_entry_t right_i,
  input  logic                found_i,
  output logic                found_o,
  output edf_pkg::edf_entry_t entry_o
);

  edf_pkg::edf_entry_t entry_q, entry_d;
  logic                goes_here;

  // empty slot or strictly larger key: the new task belongs at or before here
  assign goes_here = !occupied_i ||
                     edf_pkg::key_less(edf_pkg::key_of(new_i, ctrl_i.by_period),
                                       edf_pkg::key_of(entry_q, ctrl_i.by_period));
  assign found_o   = found_i | goes_here;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.push) begin
      if (found_i) begin
        entry_d = left_i;
      end else if (goes_here) begin
        entry_d = new_i;
      end
    end else if (ctrl_i.pop) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

### design/edf_sorted_ready_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_sorted_ready_queue: earliest-deadline-first ready queue
// sorted shift-register queue of QUEUE_DEPTH cells, head in cell 0
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+----------------------------
//  in       | in_valid_i / in_stall_o  | in_item_i   (edf_in_t)
//  out      | out_valid_o / out_stall_i| out_item_o  (edf_out_t)
//  cfg      | cfg_we_i                 | cfg_wdata_i (order_by_period)
//
//  one item per cycle while in_stall_o is low: every cell compares against the
//  new task at once and shifts in the same edge, so an item's result sits in the
//  output register from the cycle after it is taken
//  rst_ni clears the count, the order bit and the output valid; cell
//  contents are only read below the count and need no reset
//  in_stall_o rises only while a result is held under out_stall_i
// ----------------------------------------------------------------------------
module edf_sorted_ready_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  edf_pkg::edf_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output edf_pkg::edf_out_t out_item_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic                order_q;
  logic [CntW-1:0]     count_q, count_d;
  logic                out_valid_q;
  edf_pkg::edf_out_t   out_item_q;
  edf_pkg::edf_out_t   result;

  logic                in_acc;
  logic                is_push, full, empty;
  edf_pkg::edf_ctrl_t  ctrl;
  edf_pkg::edf_entry_t new_entry;
  edf_pkg::edf_key_t   head_key;
  logic [31:0]         occ_wide;

  edf_pkg::edf_entry_t cell_entry [QUEUE_DEPTH];
  logic                found [QUEUE_DEPTH+1];

  // output register parts the two sides; hold input only while it is stuck
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign is_push = (in_item_i.op == edf_pkg::OP_PUSH);
  assign full    = (count_q == CntW'(QUEUE_DEPTH));
  assign empty   = (count_q == '0);

  assign ctrl.push      = in_acc && is_push && !full;
  assign ctrl.pop       = in_acc && !is_push && !empty;
  assign ctrl.by_period = order_q;

  assign new_entry.id       = in_item_i.task_id;
  assign new_entry.rem_sec  = in_item_i.remaining_sec;
  assign new_entry.rem_usec = in_item_i.remaining_usec;
  assign new_entry.per_sec  = in_item_i.period_sec;
  assign new_entry.per_usec = in_item_i.period_usec;

  // chain of cells; found ripples from the head toward the tail
  assign found[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    edf_pkg::edf_entry_t left, right;

    if (i == 0) begin : g_head
      assign left = new_entry;
    end else begin : g_body
      assign left = cell_entry[i-1];
    end

    // tail cell keeps its own task on a pop, at or above the count after it anyway
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right = cell_entry[i];
    end else begin : g_mid
      assign right = cell_entry[i+1];
    end

    edf_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occupied_i (CntW'(i) < count_q),
      .new_i      (new_entry),
      .left_i     (left),
      .right_i    (right),
      .found_i    (found[i]),
      .found_o    (found[i+1]),
      .entry_o    (cell_entry[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.push) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  // popped key follows the order bit as it is now
  assign head_key = edf_pkg::key_of(cell_entry[0], order_q);
  assign occ_wide = 32'(count_d);

  always_comb begin
    result              = '0;
    result.occupancy    = occ_wide[edf_pkg::OccW-1:0];
    if (is_push) begin
      result.status = full ? edf_pkg::ST_PUSH_FULL : edf_pkg::ST_PUSHED;
    end else if (empty) begin
      result.status = edf_pkg::ST_POP_EMPTY;
    end else begin
      result.status       = edf_pkg::ST_POPPED;
      result.out_task_id  = cell_entry[0].id;
      result.out_key_sec  = head_key.sec;
      result.out_key_usec = head_key.usec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q     <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
